// ===== design/irsw_pkg.sv =====
// Shared types and codes for the IR swipe sequential LED core.
// No dependencies; used by the core and its port checker.
package irsw_pkg;

   // request kinds
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_APP    = 2'd1;
   localparam logic [1:0] REQ_TABLE  = 2'd2;

   // swipe machine codes
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LEFT  = 2'd1;
   localparam logic [1:0] ST_RIGHT = 2'd2;

   // result event codes
   localparam logic [2:0] EV_NONE     = 3'd0;
   localparam logic [2:0] EV_CLEAR    = 3'd1;
   localparam logic [2:0] EV_SET      = 3'd2;
   localparam logic [2:0] EV_WRAP_LR  = 3'd3;
   localparam logic [2:0] EV_WRAP_RL  = 3'd4;

   // register indexes
   localparam logic [1:0] CSR_ARM_TIMEOUT = 2'd0;
   localparam logic [1:0] CSR_COOLDOWN    = 2'd1;
   localparam logic [1:0] CSR_SEQ_LENGTH  = 2'd2;

   localparam logic [7:0] ARM_TIMEOUT_RESET = 8'd15;
   localparam logic [7:0] COOLDOWN_RESET    = 8'd25;
   localparam logic [5:0] SEQ_LENGTH_RESET  = 6'd25;
   localparam logic [8:0] TIMEOUT_MAX       = 9'd511;

   // order entry is {grid, seg}
   localparam int ENTRY_W = 7;

   typedef struct packed {
      logic [2:0] event_code;
      logic       do_led;
      logic       set_led;
      logic [5:0] next_index;
      logic [1:0] machine_state;
      logic       emitter_level;
   } ctl_type;

endpackage

// ===== design/irsw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module irsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold read data while stalled
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ir_swipe_sequential_led_core.sv =====
// IR swipe sequential LED core: swipe machine, order store and display store.
// Depends on irsw_pkg and irsw_ram.
//
// The core takes one item per cycle while no result is stalled. For each
// accepted item the swipe machine and counters update in the accept cycle
// while the order store is read, the entry then addresses the display store,
// and the last stage modifies and writes back the display byte and loads the
// result register. The whole pipeline stalls only while a
// result waits in the output register. Two completed swipes are always at
// least two sample items apart, so a display write lands before the next
// swipe reads. The display store reads as zero after reset through one valid
// bit per byte; order entries read before being written return arbitrary data.
module ir_swipe_sequential_led_core #(
   parameter int ORDER_DEPTH = 32,
   parameter int GRID_COUNT  = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic       req_left_level,
   input  logic       req_right_level,
   input  logic [4:0] req_table_index,
   input  logic [2:0] req_table_seg,
   input  logic [3:0] req_table_grid,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_event_code,
   output logic [3:0] rsp_changed_grid,
   output logic [7:0] rsp_changed_byte,
   output logic [5:0] rsp_next_index,
   output logic [1:0] rsp_machine_state,
   output logic       rsp_emitter_level,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int OAW = (ORDER_DEPTH > 1) ? $clog2(ORDER_DEPTH) : 1;
   localparam int GAW = (GRID_COUNT > 1) ? $clog2(GRID_COUNT) : 1;

   // configuration
   logic [7:0] arm_timeout_ff;
   logic [7:0] cooldown_ticks_ff;
   logic [5:0] seq_length_ff;

   // swipe machine state
   logic [1:0] arm_state_ff, arm_state_in;
   logic [8:0] timeout_ff, timeout_in;
   logic [7:0] cooldown_ff, cooldown_in;
   logic [5:0] seq_index_ff, seq_index_in;
   logic       emitter_ff, emitter_in;

   logic               move;
   logic               accept;
   irsw_pkg::ctl_type  ctl0;

   // stage 1: order entry read
   logic               s1_valid_ff;
   irsw_pkg::ctl_type  s1_ctl_ff;
   // stage 2: display byte read
   logic               s2_valid_ff;
   irsw_pkg::ctl_type  s2_ctl_ff;
   logic [2:0]         s2_seg_ff;
   logic [3:0]         s2_grid_ff;
   logic               s2_grid_ok_ff;
   logic               s2_dvalid_ff;
   logic [GAW-1:0]     s2_gaddr_ff;

   logic [GRID_COUNT-1:0] disp_valid_ff;

   logic                        order_we;
   logic [irsw_pkg::ENTRY_W-1:0] order_rdata;
   logic [3:0]                  s1_grid;
   logic [GAW-1:0]              s1_gaddr;
   logic                        s1_grid_ok;
   logic                        s1_dvalid;

   logic [7:0] disp_rdata;
   logic [7:0] old_byte;
   logic [7:0] seg_mask;
   logic [7:0] new_byte;
   logic       disp_we;

   // result register
   logic       rsp_valid_ff;
   logic [2:0] rsp_event_ff;
   logic [3:0] rsp_grid_ff;
   logic [7:0] rsp_byte_ff;
   logic [5:0] rsp_index_ff;
   logic [1:0] rsp_state_ff;
   logic       rsp_emitter_ff;

   assign move      = !rsp_valid_ff || rsp_ready;
   assign req_ready = move;
   assign accept    = req_valid && move;

   // ---------------------------------------------------------------
   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         arm_timeout_ff    <= irsw_pkg::ARM_TIMEOUT_RESET;
         cooldown_ticks_ff <= irsw_pkg::COOLDOWN_RESET;
         seq_length_ff     <= irsw_pkg::SEQ_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            irsw_pkg::CSR_ARM_TIMEOUT: arm_timeout_ff    <= csr_wdata;
            irsw_pkg::CSR_COOLDOWN:    cooldown_ticks_ff <= csr_wdata;
            irsw_pkg::CSR_SEQ_LENGTH:  seq_length_ff     <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // swipe machine, evaluated for the item being accepted
   always_comb begin
      logic finish;
      logic set_led;
      logic in_range;
      arm_state_in = arm_state_ff;
      timeout_in   = timeout_ff;
      cooldown_in  = cooldown_ff;
      seq_index_in = seq_index_ff;
      emitter_in   = emitter_ff;
      finish       = 1'b0;
      set_led      = 1'b0;
      in_range     = (32'(seq_index_ff) < 32'(seq_length_ff)) &&
                     (32'(seq_index_ff) < ORDER_DEPTH);
      case (req_type)
         irsw_pkg::REQ_SAMPLE: begin
            emitter_in = ~emitter_ff;
            if (arm_state_ff == irsw_pkg::ST_IDLE && cooldown_ff == 8'd0) begin
               if (req_left_level && !req_right_level) begin
                  arm_state_in = irsw_pkg::ST_LEFT;
                  timeout_in   = '0;
               end else if (req_right_level && !req_left_level) begin
                  arm_state_in = irsw_pkg::ST_RIGHT;
                  timeout_in   = '0;
               end
            end
            if (arm_state_in == irsw_pkg::ST_LEFT || arm_state_in == irsw_pkg::ST_RIGHT) begin
               set_led = (arm_state_in == irsw_pkg::ST_RIGHT);
               finish  = set_led ? req_left_level : req_right_level;
               if (finish) begin
                  arm_state_in = irsw_pkg::ST_IDLE;
                  cooldown_in  = cooldown_ticks_ff;
                  seq_index_in = in_range ? seq_index_ff + 6'd1 : 6'd0;
               end
               // timeout runs even on the tick that completed the swipe
               if (timeout_in != irsw_pkg::TIMEOUT_MAX) begin
                  timeout_in = timeout_in + 9'd1;
               end
               if (timeout_in > {1'b0, arm_timeout_ff}) begin
                  arm_state_in = irsw_pkg::ST_IDLE;
               end
            end
         end
         irsw_pkg::REQ_APP: begin
            if (cooldown_ff != 8'd0) begin
               cooldown_in = cooldown_ff - 8'd1;
            end
         end
         default: ;
      endcase
      if (!finish) begin
         ctl0.event_code = irsw_pkg::EV_NONE;
      end else if (in_range) begin
         ctl0.event_code = set_led ? irsw_pkg::EV_SET : irsw_pkg::EV_CLEAR;
      end else begin
         ctl0.event_code = set_led ? irsw_pkg::EV_WRAP_RL : irsw_pkg::EV_WRAP_LR;
      end
      ctl0.do_led        = finish && in_range;
      ctl0.set_led       = set_led;
      ctl0.next_index    = seq_index_in;
      ctl0.machine_state = arm_state_in;
      ctl0.emitter_level = emitter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_state_ff <= irsw_pkg::ST_IDLE;
         timeout_ff   <= '0;
         cooldown_ff  <= '0;
         seq_index_ff <= '0;
         emitter_ff   <= 1'b0;
      end else if (accept) begin
         arm_state_ff <= arm_state_in;
         timeout_ff   <= timeout_in;
         cooldown_ff  <= cooldown_in;
         seq_index_ff <= seq_index_in;
         emitter_ff   <= emitter_in;
      end
   end

   // ---------------------------------------------------------------
   // order store: written by table items, read at the current index
   assign order_we = accept && (req_type == irsw_pkg::REQ_TABLE) &&
                     (32'(req_table_index) < ORDER_DEPTH);

   irsw_ram #(
      .WIDTH (irsw_pkg::ENTRY_W),
      .DEPTH (ORDER_DEPTH)
   ) u_order_ram (
      .clock   (clock),
      .wr_en   (order_we),
      .wr_addr (OAW'(req_table_index)),
      .wr_data ({req_table_grid, req_table_seg}),
      .rd_en   (move),
      .rd_addr (OAW'(seq_index_ff)),
      .rd_data (order_rdata)
   );

   // ---------------------------------------------------------------
   // stage 1: address the display byte
   assign s1_grid    = order_rdata[6:3];
   assign s1_gaddr   = GAW'(s1_grid);
   assign s1_grid_ok = 32'(s1_grid) < GRID_COUNT;
   assign s1_dvalid  = s1_grid_ok ? disp_valid_ff[s1_gaddr] : 1'b0;

   irsw_ram #(
      .WIDTH (8),
      .DEPTH (GRID_COUNT)
   ) u_disp_ram (
      .clock   (clock),
      .wr_en   (disp_we),
      .wr_addr (s2_gaddr_ff),
      .wr_data (new_byte),
      .rd_en   (move),
      .rd_addr (s1_gaddr),
      .rd_data (disp_rdata)
   );

   // ---------------------------------------------------------------
   // stage 2: modify and write back
   assign old_byte = s2_dvalid_ff ? disp_rdata : 8'h00;
   assign seg_mask = 8'h01 << s2_seg_ff;
   assign new_byte = s2_ctl_ff.set_led ? (old_byte | seg_mask) : (old_byte & ~seg_mask);
   assign disp_we  = move && s2_valid_ff && s2_ctl_ff.do_led && s2_grid_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         disp_valid_ff <= '0;
      end else begin
         if (move) begin
            s1_valid_ff  <= accept;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff;
         end
         if (disp_we) begin
            disp_valid_ff[s2_gaddr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         s1_ctl_ff      <= ctl0;
         s2_ctl_ff      <= s1_ctl_ff;
         s2_seg_ff      <= order_rdata[2:0];
         s2_grid_ff     <= s1_grid;
         s2_grid_ok_ff  <= s1_grid_ok;
         s2_dvalid_ff   <= s1_dvalid;
         s2_gaddr_ff    <= s1_gaddr;
         rsp_event_ff   <= s2_ctl_ff.event_code;
         rsp_grid_ff    <= s2_ctl_ff.do_led ? s2_grid_ff : 4'd0;
         rsp_byte_ff    <= (s2_ctl_ff.do_led && s2_grid_ok_ff) ? new_byte : 8'd0;
         rsp_index_ff   <= s2_ctl_ff.next_index;
         rsp_state_ff   <= s2_ctl_ff.machine_state;
         rsp_emitter_ff <= s2_ctl_ff.emitter_level;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_code    = rsp_event_ff;
   assign rsp_changed_grid  = rsp_grid_ff;
   assign rsp_changed_byte  = rsp_byte_ff;
   assign rsp_next_index    = rsp_index_ff;
   assign rsp_machine_state = rsp_state_ff;
   assign rsp_emitter_level = rsp_emitter_ff;

endmodule

// ===== design/irsw_checker.sv =====
// Port-level checks for the IR swipe sequential LED core, bound to the top.
// Depends on irsw_pkg.
module irsw_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_event_code,
   input logic [3:0] rsp_changed_grid,
   input logic [7:0] rsp_changed_byte,
   input logic [5:0] rsp_next_index,
   input logic [1:0] rsp_machine_state,
   input logic       rsp_emitter_level
);

   // a stalled result item holds its event code, byte, index and emitter level
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code) &&
      $stable(rsp_changed_byte) && $stable(rsp_next_index) &&
      $stable(rsp_emitter_level))
      else $error("result item changed while stalled");

   // input side stops while a result waits
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

   // a wrap restarts the sequence and touches no LED
   a_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_code == irsw_pkg::EV_WRAP_LR ||
                    rsp_event_code == irsw_pkg::EV_WRAP_RL)
      |-> rsp_next_index == 6'd0 && rsp_changed_grid == 4'd0 &&
          rsp_changed_byte == 8'd0)
      else $error("wrap event with LED change or nonzero index");

   // a completed swipe leaves the machine idle
   a_swipe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_code != irsw_pkg::EV_NONE
      |-> rsp_machine_state == irsw_pkg::ST_IDLE)
      else $error("machine armed after completed swipe");

endmodule

bind ir_swipe_sequential_led_core irsw_checker u_irsw_checker (.*);
